// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL folder.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: lbl");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition: lbl");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: hdl/rspe_pkg.sv
// ----------------------------------------------------------------------------
// rspe_pkg
// Types, constants and GF(256) helpers for the Reed-Solomon parity encoder.
// ----------------------------------------------------------------------------
package rspe_pkg;

    // Field polynomial x^8+x^4+x^3+x^2+1, low byte only
    localparam logic [7:0] GF_POLY_LOW = 8'h1D;
    // Generator element alpha
    localparam logic [7:0] GF_ALPHA    = 8'h02;
    // Parity length after reset
    localparam logic [4:0] LEN_RESET   = 5'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       last_parity;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_BUILD,
        ST_PREP,
        ST_ENC,
        ST_OUT
    } t_state;

    // Multiply by alpha: one shift and a conditional reduction
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
    endfunction

    // Full GF(256) product, MSB first shift-and-add
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int bit_i = 7; bit_i >= 0; bit_i--) begin
            acc = gf_xtime(acc);
            if (b[bit_i]) begin
                acc = acc ^ a;
            end
        end
        gf_mul = acc;
    endfunction

endpackage

// File: hdl/rs_parity_encoder.sv
// Sequence: a data byte passes accept, feedback fetch and n multiply-accumulate
// steps on the one shared GF multiplier, n = effective parity length; no new byte
// is taken meanwhile. A byte marked last adds n readout steps, one parity byte per
// cycle unless stalled. A change of n adds a clear sweep and rebuild before the byte.
// Reset: synchronous, active low; length returns to 10 and the generator is rebuilt
// on the first byte, which also clears the remainder.
// ----------------------------------------------------------------------------
// rs_parity_encoder
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
// Generator coefficients and the remainder live in small register files that a sequencer
// sweeps one entry per cycle, held while the output stalls, through a single GF multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rs_parity_encoder #(
    parameter int MAX_PARITY = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // data bytes in
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rspe_pkg::t_in     i_in,
    // parity bytes out
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rspe_pkg::t_out    o_out,
    // parity length register
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [4:0]        i_cfg_data
);
    import rspe_pkg::*;

    localparam int IDX_W = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int CNT_W = $clog2(MAX_PARITY + 1);
    localparam int LW    = (CNT_W > 5) ? CNT_W : 5;

    t_state            r_state, n_state;
    logic [4:0]        r_len;
    logic [CNT_W-1:0]  r_built, n_built;
    logic [IDX_W-1:0]  r_top, n_top;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [IDX_W-1:0]  r_step, n_step;
    logic [7:0]        r_root, n_root;
    logic [7:0]        r_prev, n_prev;
    logic [7:0]        r_factor, n_factor;
    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic [7:0]        r_gen [MAX_PARITY];
    logic [7:0]        r_rem [MAX_PARITY];

    logic [LW-1:0]     w_len_wide;
    logic [CNT_W-1:0]  w_n_eff;
    logic [CNT_W-1:0]  w_cur_len;
    logic              w_in_acc;
    logic              w_k_top;
    logic              w_load;
    logic              w_out_take;
    logic [IDX_W-1:0]  w_rem_ridx;
    logic [7:0]        w_g_rd;
    logic [7:0]        w_rem_rd;
    logic [7:0]        w_mul_b;
    logic [7:0]        w_prod;
    logic              w_g_we;
    logic [7:0]        w_g_wdata;
    logic              w_rem_we;
    logic [7:0]        w_rem_wdata;

    // Configuration: always ready, length captured as written
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_len <= i_cfg_data;
        end
    end

    // Effective length: zero reads as one, saturate at the storage depth
    always_comb begin
        w_len_wide = LW'(r_len);
        if (w_len_wide == '0) begin
            w_n_eff = CNT_W'(1);
        end else if (w_len_wide > LW'(MAX_PARITY)) begin
            w_n_eff = CNT_W'(MAX_PARITY);
        end else begin
            w_n_eff = CNT_W'(w_len_wide);
        end
    end

    assign w_cur_len  = CNT_W'(r_top) + CNT_W'(1);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_k_top    = (r_k == r_top);
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_load     = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    // Register file reads: one address each, plus the fixed head of the remainder
    assign w_rem_ridx = ((r_state == ST_ENC) && !w_k_top) ? r_k + IDX_W'(1) : r_k;
    assign w_g_rd     = r_gen[r_k];
    assign w_rem_rd   = r_rem[w_rem_ridx];

    // Shared GF multiplier
    assign w_mul_b = (r_state == ST_BUILD) ? r_root : r_factor;
    assign w_prod  = gf_mul(w_g_rd, w_mul_b);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_built     <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_step      <= '0;
            r_top       <= '0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_step      <= n_step;
            r_top       <= n_top;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_root   <= n_root;
        r_prev   <= n_prev;
        r_factor <= n_factor;
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_out    <= n_out;
    end

    // Register file writes, one entry per cycle at the sweep index
    always_ff @(posedge i_clk) begin
        if (w_g_we) begin
            r_gen[r_k] <= w_g_wdata;
        end
        if (w_rem_we) begin
            r_rem[r_k] <= w_rem_wdata;
        end
    end

    // Sequencer: next state, sweep control and register file writes
    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_top       = r_top;
        n_k         = r_k;
        n_step      = r_step;
        n_root      = r_root;
        n_prev      = r_prev;
        n_factor    = r_factor;
        n_byte      = r_byte;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = w_load || (r_out_valid && !w_out_take);
        w_g_we      = 1'b0;
        w_g_wdata   = 8'h00;
        w_rem_we    = 1'b0;
        w_rem_wdata = 8'h00;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_byte = i_in.data_byte;
                    n_last = i_in.last_byte;
                    n_top  = IDX_W'(w_n_eff - CNT_W'(1));
                    if (r_built != w_n_eff) begin
                        n_k     = IDX_W'(w_n_eff - CNT_W'(1));
                        n_state = ST_INIT;
                    end else begin
                        n_state = ST_PREP;
                    end
                end
            end

            // Clear sweep: remainder to zero, generator to the monic constant 1
            ST_INIT: begin
                w_g_we    = 1'b1;
                w_g_wdata = w_k_top ? 8'h01 : 8'h00;
                w_rem_we  = 1'b1;
                if (r_k == '0) begin
                    n_k     = r_top;
                    n_step  = '0;
                    n_root  = 8'h01;
                    n_prev  = 8'h00;
                    n_state = ST_BUILD;
                end else begin
                    n_k = r_k - IDX_W'(1);
                end
            end

            // Multiply the generator by (x - root), highest index first
            ST_BUILD: begin
                w_g_we    = 1'b1;
                w_g_wdata = w_prod ^ (w_k_top ? 8'h00 : r_prev);
                n_prev    = w_g_rd;
                if (r_k == '0) begin
                    if (r_step == r_top) begin
                        n_built = w_cur_len;
                        n_state = ST_PREP;
                    end else begin
                        n_step = r_step + IDX_W'(1);
                        n_root = gf_xtime(r_root);
                        n_k    = r_top;
                    end
                end else begin
                    n_k = r_k - IDX_W'(1);
                end
            end

            // Fetch the feedback byte
            ST_PREP: begin
                n_factor = r_byte ^ r_rem[0];
                n_k      = '0;
                n_state  = ST_ENC;
            end

            // Shift the remainder and add feedback times each coefficient
            ST_ENC: begin
                w_rem_we    = 1'b1;
                w_rem_wdata = (w_k_top ? 8'h00 : w_rem_rd) ^ w_prod;
                if (w_k_top) begin
                    n_k     = '0;
                    n_state = r_last ? ST_OUT : ST_IDLE;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end

            // Stream the remainder out and clear each entry behind it
            ST_OUT: begin
                if (w_load) begin
                    n_out.parity_byte = w_rem_rd;
                    n_out.last_parity = w_k_top;
                    w_rem_we          = 1'b1;
                    if (w_k_top) begin
                        n_k     = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A length change must send the transaction through the rebuild
    `ASSERT_PROP(a_rebuild_on_change, i_clk, i_rst_n, (w_in_acc && (r_built != w_n_eff)) |=> (r_state == ST_INIT))
    // Encoding only runs against coefficients built for the current length
    `ASSERT_NEVER(a_enc_built_match, i_clk, i_rst_n, (r_state == ST_ENC) && (r_built != w_cur_len))
    // The output register only changes content while streaming parity
    `ASSERT_PROP(a_out_hold, i_clk, i_rst_n, (r_state != ST_OUT) |=> (!r_out_valid || $stable(r_out)))
    // The final parity byte ends the readout
    `ASSERT_PROP(a_last_ends_out, i_clk, i_rst_n, (w_load && w_k_top) |=> (r_state == ST_IDLE && r_out.last_parity))

endmodule
